// ----- sv/spg_pkg.sv -----
// ----------------------------------------------------------------------------
// Swap permutation generator package
// Sizes, operation codes, microcode types and the control and status
// structs shared by the sequencer, the datapath and the top level.
// ----------------------------------------------------------------------------
package spg_pkg;

	localparam int MAX_ELEMS  = 8;
	localparam int ELEM_WIDTH = 16;

	localparam int IDX_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
	localparam int NUM_W = $clog2(MAX_ELEMS + 1);

	localparam int CNT_W     = 4;
	localparam int SLOT_W    = 3;
	localparam int VALUE_W   = 16;
	localparam int POS_W     = 3;
	localparam int OP_W      = 2;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 24;
	localparam int M_PAD_W   = M_TDATA_W - VALUE_W - POS_W;

	localparam logic [CNT_W-1:0] ELEM_COUNT_RESET = 4'd3;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_ELEM_COUNT = 1'b0;

	localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
	localparam logic [OP_W-1:0] OP_NEXT    = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

	localparam int PROG_LEN = 8;
	localparam int PC_W     = $clog2(PROG_LEN);

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_ACCEPT,
		ACT_SCAN_INIT,
		ACT_DEC,
		ACT_BUMP,
		ACT_WRAP,
		ACT_COPY,
		ACT_EMIT
	} act_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NOT_EMIT_CMD,
		COND_NOT_STARTED,
		COND_SK_ZERO,
		COND_CANT_BUMP,
		COND_EMIT_MORE
	} cond_t;

	typedef struct packed {
		act_t            act;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic emit_cmd;
		logic started;
		logic sk_zero;
		logic can_bump;
		logic last_taken;
	} stat_t;

endpackage

// ----- sv/spg_sequencer.sv -----
// ----------------------------------------------------------------------------
// Swap permutation generator microcode sequencer
// Step counter over a read-only control program with one conditional jump
// per control word.
// ----------------------------------------------------------------------------
module spg_sequencer import spg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	localparam logic [PC_W-1:0] STEP_WAIT  = 3'd0;
	localparam logic [PC_W-1:0] STEP_SCAN  = 3'd2;
	localparam logic [PC_W-1:0] STEP_WRAP  = 3'd5;
	localparam logic [PC_W-1:0] STEP_COPY  = 3'd6;
	localparam logic [PC_W-1:0] STEP_EMIT  = 3'd7;

	localparam ctrl_t PROGRAM [PROG_LEN] = '{
		'{ACT_ACCEPT,    COND_NOT_EMIT_CMD, STEP_WAIT},
		'{ACT_SCAN_INIT, COND_NOT_STARTED,  STEP_WRAP},
		'{ACT_DEC,       COND_SK_ZERO,      STEP_WRAP},
		'{ACT_NONE,      COND_CANT_BUMP,    STEP_SCAN},
		'{ACT_BUMP,      COND_ALWAYS,       STEP_COPY},
		'{ACT_WRAP,      COND_NEVER,        STEP_COPY},
		'{ACT_COPY,      COND_NEVER,        STEP_EMIT},
		'{ACT_EMIT,      COND_EMIT_MORE,    STEP_EMIT}
	};

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_next;
	logic            take;

	always_comb begin
		ctrl = PROGRAM[pc_q];
		case (ctrl.cond)
			COND_NEVER:        take = 1'b0;
			COND_ALWAYS:       take = 1'b1;
			COND_NOT_EMIT_CMD: take = !stat.emit_cmd;
			COND_NOT_STARTED:  take = !stat.started;
			COND_SK_ZERO:      take = stat.sk_zero;
			COND_CANT_BUMP:    take = !stat.can_bump;
			COND_EMIT_MORE:    take = !stat.last_taken;
			default:           take = 1'b0;
		endcase
		if (take) begin
			pc_next = ctrl.target;
		end else if (pc_q == PC_W'(PROG_LEN - 1)) begin
			pc_next = STEP_WAIT;
		end else begin
			pc_next = pc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_WAIT;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

// ----- sv/spg_datapath.sv -----
// ----------------------------------------------------------------------------
// Swap permutation generator datapath
// Element store, choice stack, scan and beat counters and the work row that
// applies the swaps one position per beat while the results stream out.
// ----------------------------------------------------------------------------
module spg_datapath import spg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctrl_t                ctrl,
	output stat_t                stat,
	input  logic [CNT_W-1:0]     elem_count,
	input  logic                 cfg_wr,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [OP_W-1:0]      s_tuser,
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tlast,
	output logic                 m_tuser
);

	logic [ELEM_WIDTH-1:0] store_q [MAX_ELEMS];
	logic [ELEM_WIDTH-1:0] work_q  [MAX_ELEMS];
	logic [IDX_W-1:0]      cs_q    [MAX_ELEMS];
	logic                  started_q;
	logic [IDX_W-1:0]      sk_q;
	logic [IDX_W-1:0]      pk_q;

	logic [NUM_W-1:0]   n_act;
	logic [IDX_W-1:0]   n_m1;
	logic [OP_W-1:0]    op;
	logic [SLOT_W-1:0]  slot;
	logic [VALUE_W-1:0] value;
	logic               in_fire;
	logic               m_fire;
	logic               last;
	logic               fin;
	logic [IDX_W-1:0]   cur_j;
	logic [IDX_W-1:0]   d_sel;
	logic [POS_W-1:0]   position;
	logic [VALUE_W-1:0] elem_value;

	assign op    = s_tuser;
	assign slot  = s_tdata[SLOT_W-1:0];
	assign value = s_tdata[SLOT_W+VALUE_W-1:SLOT_W];

	assign s_tready = (ctrl.act == ACT_ACCEPT);
	assign in_fire  = s_tvalid && s_tready;
	assign m_tvalid = (ctrl.act == ACT_EMIT);
	assign m_fire   = m_tvalid && m_tready;

	always_comb begin
		if (elem_count == '0) begin
			n_act = NUM_W'(1);
		end else if (int'(elem_count) > MAX_ELEMS) begin
			n_act = NUM_W'(MAX_ELEMS);
		end else begin
			n_act = NUM_W'(elem_count);
		end
	end

	assign n_m1 = IDX_W'(n_act - 1'b1);
	assign last = (pk_q == n_m1);

	always_comb begin
		fin = 1'b1;
		for (int k = 0; k < MAX_ELEMS - 1; k++) begin
			if ((k + 1 < int'(n_act)) && (cs_q[k] != n_m1)) begin
				fin = 1'b0;
			end
		end
	end

	always_comb begin
		cur_j = cs_q[pk_q];
		if (last || (NUM_W'(cur_j) >= n_act) || (cur_j < pk_q)) begin
			d_sel = '0;
		end else begin
			d_sel = cur_j - pk_q;
		end
	end

	assign elem_value = VALUE_W'(work_q[d_sel]);
	assign position   = POS_W'(pk_q);
	assign m_tdata    = {{M_PAD_W{1'b0}}, position, elem_value};
	assign m_tlast    = last;
	assign m_tuser    = fin;

	assign stat.emit_cmd   = in_fire && (op == OP_NEXT);
	assign stat.started    = started_q;
	assign stat.sk_zero    = (sk_q == '0);
	assign stat.can_bump   = ((NUM_W'(cs_q[sk_q]) + 1'b1) < n_act);
	assign stat.last_taken = m_fire && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_ELEMS; k++) begin
				store_q[k] <= '0;
				cs_q[k]    <= '0;
			end
			started_q <= 1'b0;
			sk_q      <= '0;
			pk_q      <= '0;
		end else begin
			if (in_fire && (op == OP_LOAD) && (int'(slot) < MAX_ELEMS)) begin
				store_q[IDX_W'(slot)] <= ELEM_WIDTH'(value);
			end
			if (cfg_wr || (in_fire && ((op == OP_LOAD) || (op == OP_RESTART)))) begin
				started_q <= 1'b0;
			end else if (ctrl.act == ACT_WRAP) begin
				started_q <= 1'b1;
			end
			case (ctrl.act)
				ACT_SCAN_INIT: begin
					sk_q <= n_m1;
				end
				ACT_DEC: begin
					sk_q <= sk_q - 1'b1;
				end
				ACT_BUMP: begin
					for (int k = 0; k < MAX_ELEMS; k++) begin
						if (IDX_W'(k) == sk_q) begin
							cs_q[k] <= cs_q[k] + 1'b1;
						end else if ((IDX_W'(k) > sk_q) && (k < int'(n_act))) begin
							cs_q[k] <= IDX_W'(k);
						end
					end
				end
				ACT_WRAP: begin
					for (int k = 0; k < MAX_ELEMS; k++) begin
						if (k < int'(n_act)) begin
							cs_q[k] <= IDX_W'(k);
						end
					end
				end
				ACT_COPY: begin
					pk_q <= '0;
				end
				ACT_EMIT: begin
					if (m_fire) begin
						pk_q <= pk_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Position pk is final once it has been swapped, so the row shifts toward
	// its head after each beat and the old head element moves into the partner's gap.
	always_ff @(posedge clk) begin
		if (ctrl.act == ACT_COPY) begin
			work_q <= store_q;
		end else if (m_fire) begin
			for (int i = 0; i < MAX_ELEMS - 1; i++) begin
				if (IDX_W'(i + 1) == d_sel) begin
					work_q[i] <= work_q[0];
				end else begin
					work_q[i] <= work_q[i + 1];
				end
			end
		end
	end

endmodule

// ----- sv/swap_permutation_generator_core.sv -----
// ----------------------------------------------------------------------------
// Swap permutation generator core
// Load and restart beats are taken while the sequencer waits. A next beat
// has the sequencer scan L stack levels (at most n-1), then gives n
// result beats, one per cycle without backpressure; a scan that wraps to the
// first order also runs the wrap step. One item at a time.
// Asynchronous active-low reset clears the store and the choice stack to
// zero and sets elem_count to 3; the first next beat gives the first order.
// ----------------------------------------------------------------------------
module swap_permutation_generator_core import spg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [OP_W-1:0]       s_tuser,  // op
	input  logic [S_TDATA_W-1:0]  s_tdata,  // slot, value, zero pad
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,  // elem_value, position, zero pad
	output logic                  m_tlast,  // last_in_perm
	output logic                  m_tuser   // final_perm
);

	logic [CNT_W-1:0] elem_count_q;
	logic             cfg_wr;
	ctrl_t            ctrl;
	stat_t            stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ELEM_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_count_q <= ELEM_COUNT_RESET;
		end else if (cfg_wr) begin
			elem_count_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_ELEM_COUNT) ? APB_DATA_W'(elem_count_q) : '0;

	spg_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	spg_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.stat       (stat),
		.elem_count (elem_count_q),
		.cfg_wr     (cfg_wr),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tuser    (s_tuser),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule

// ----- sim/swap_permutation_generator_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Swap permutation generator checker
// Watches the register port and both streams. It keeps its own element
// store, choice stack and count, and predicts every permutation beat on each
// accepted next beat. Each output beat is compared with the oldest
// prediction. Mismatches, unexpected beats and the number of predictions
// still waiting are reported to the test top.
// ----------------------------------------------------------------------------
module swap_permutation_generator_checker import spg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic                  pready,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [OP_W-1:0]       s_tuser,  // op
	input  logic [S_TDATA_W-1:0]  s_tdata,  // slot, value, zero pad
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [M_TDATA_W-1:0]  m_tdata,  // elem_value, position, zero pad
	input  logic                  m_tlast,  // last_in_perm
	input  logic                  m_tuser,  // final_perm
	output int                    fail_count,
	output int                    pending_beats
);

	localparam logic [APB_ADDR_W-1:0] COUNT_ADDR = APB_ADDR_W'(4 * int'(REG_ELEM_COUNT));

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [POS_W-1:0]   position;
		logic               last;
		logic               fin;
	} perm_beat_t;

	perm_beat_t         perm_q[$];
	logic [VALUE_W-1:0] elem_store [MAX_ELEMS];
	logic [CNT_W-1:0]   choice [MAX_ELEMS];
	logic               started;
	logic [CNT_W-1:0]   elem_count;
	int                 errors;

	function automatic int active_count();
		int n;
		n = int'(elem_count);
		if (n == 0) begin
			n = 1;
		end
		if (n > MAX_ELEMS) begin
			n = MAX_ELEMS;
		end
		return n;
	endfunction

	function automatic void rewind_choice(int from, int n);
		for (int k = from; k < n; k++) begin
			choice[k] = CNT_W'(k);
		end
	endfunction

	function automatic void predict_permutation();
		int                 n;
		int                 k;
		int                 j;
		logic               bumped;
		logic               fin;
		logic [VALUE_W-1:0] work [MAX_ELEMS];
		logic [VALUE_W-1:0] t;
		n = active_count();
		if (!started) begin
			rewind_choice(0, n);
			started = 1'b1;
		end else begin
			// Odometer step: the deepest level moves fastest.
			bumped = 1'b0;
			k = n - 1;
			while (k > 0 && !bumped) begin
				k--;
				if (int'(choice[k]) + 1 < n) begin
					choice[k] = choice[k] + 1'b1;
					rewind_choice(k + 1, n);
					bumped = 1'b1;
				end
			end
			if (!bumped) begin
				rewind_choice(0, n);
			end
		end
		for (k = 0; k < MAX_ELEMS; k++) begin
			work[k] = elem_store[k];
		end
		for (k = 0; k + 1 < n; k++) begin
			j = int'(choice[k]);
			if (j >= n || j < k) begin
				j = k;
			end
			t = work[k];
			work[k] = work[j];
			work[j] = t;
		end
		fin = 1'b1;
		for (k = 0; k + 1 < n; k++) begin
			if (int'(choice[k]) != n - 1) begin
				fin = 1'b0;
			end
		end
		for (k = 0; k < n; k++) begin
			perm_q.push_back('{work[k], POS_W'(k), k == n - 1, fin});
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		perm_beat_t exp_beat;
		perm_beat_t got_beat;
		if (!arst_n) begin
			for (int k = 0; k < MAX_ELEMS; k++) begin
				elem_store[k] = '0;
				choice[k] = '0;
			end
			started = 1'b0;
			elem_count = ELEM_COUNT_RESET;
			perm_q.delete();
			errors = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == COUNT_ADDR) begin
				elem_count = pwdata[CNT_W-1:0];
				started = 1'b0;
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					OP_LOAD: begin
						elem_store[s_tdata[SLOT_W-1:0]] = s_tdata[SLOT_W +: VALUE_W];
						started = 1'b0;
					end
					OP_NEXT: begin
						predict_permutation();
					end
					OP_RESTART: begin
						started = 1'b0;
					end
					default: begin
					end
				endcase
			end
			if (m_tvalid && m_tready) begin
				got_beat = '{m_tdata[VALUE_W-1:0], m_tdata[VALUE_W +: POS_W], m_tlast, m_tuser};
				if (perm_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat, expected none, got value %h pos %0d last %b final %b",
						$time, got_beat.value, got_beat.position, got_beat.last, got_beat.fin);
				end else begin
					exp_beat = perm_q.pop_front();
					if (got_beat.value !== exp_beat.value ||
							got_beat.position !== exp_beat.position ||
							got_beat.last !== exp_beat.last ||
							got_beat.fin !== exp_beat.fin) begin
						errors++;
						$display("%0t: beat mismatch, expected value %h pos %0d last %b final %b, got value %h pos %0d last %b final %b",
							$time, exp_beat.value, exp_beat.position, exp_beat.last, exp_beat.fin,
							got_beat.value, got_beat.position, got_beat.last, got_beat.fin);
					end
				end
			end
		end
		fail_count <= errors;
		pending_beats <= perm_q.size();
	end

endmodule

// ----- sim/swap_permutation_generator_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Swap permutation generator core test
// Drives load, next, restart and unused op beats plus element count writes,
// first a directed pass over the corner cases, then random phases with and
// without input gaps and output stalls, one long output hold-off included.
// The checker predicts and compares; this top makes stimulus and decides.
// ----------------------------------------------------------------------------
module swap_permutation_generator_core_test import spg_pkg::*;;

	localparam logic [APB_ADDR_W-1:0] COUNT_ADDR = APB_ADDR_W'(4 * int'(REG_ELEM_COUNT));
	localparam logic [OP_W-1:0]       OP_UNUSED  = 2'd3;
	localparam int                    DRAIN_WAIT = 40;
	localparam int                    HOLD_LEN   = 300;
	localparam int                    IDLE_LIMIT = 3000;
	localparam int                    PHASES     = 5;
	localparam int                    PHASE_LEN  = 52;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [OP_W-1:0]       s_tuser = OP_RESTART;  // op
	logic [S_TDATA_W-1:0]  s_tdata = '0;          // slot, value, zero pad
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;               // elem_value, position, zero pad
	logic                  m_tlast;               // last_in_perm
	logic                  m_tuser;               // final_perm

	int fail_count;
	int pending_beats;
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	swap_permutation_generator_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	swap_permutation_generator_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tuser       (s_tuser),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.m_tuser       (m_tuser),
		.fail_count    (fail_count),
		.pending_beats (pending_beats)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// The output side stalls at random, or holds off entirely when asked.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_LEN;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_item(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
			logic [VALUE_W-1:0] value);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= S_TDATA_W'({value, slot});
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_random(logic [OP_W-1:0] op);
		send_item(op, SLOT_W'($urandom), VALUE_W'($urandom));
	endtask

	// Waits for every predicted beat, then lets the core finish any work
	// that produces no beats before the register is touched.
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_beats != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_count(logic [CNT_W-1:0] count);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= COUNT_ADDR;
		pwdata <= APB_DATA_W'(count);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		int phase_idle [PHASES];
		int phase_stall [PHASES];
		int phase_count [PHASES];
		logic [VALUE_W-1:0] load_vals [8];
		int sent;
		int perms;
		int run_len;
		phase_idle = '{0, 58, 0, 25, 0};
		phase_stall = '{0, 0, 58, 25, 0};
		phase_count = '{4, 2, 3, 8, 5};
		load_vals = '{16'hFFFF, 16'h0000, 16'h8001, 16'h7FFE,
			16'hAAAA, 16'h5555, 16'h00FF, 16'hFF00};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset count of three: the full enumeration, the wrap, restart,
		// an ignored op and a load in the middle of an enumeration.
		for (int k = 0; k < 8; k++) begin
			send_item(OP_LOAD, SLOT_W'(k), load_vals[k]);
		end
		repeat (7) send_random(OP_NEXT);
		send_random(OP_RESTART);
		send_random(OP_NEXT);
		send_random(OP_UNUSED);
		send_random(OP_NEXT);
		send_item(OP_LOAD, 3'd1, 16'h1234);
		send_random(OP_NEXT);

		// Count of zero and of one give a single, always final order;
		// counts above the store size clamp to it.
		settle();
		write_count(4'd0);
		send_random(OP_NEXT);
		settle();
		write_count(4'd1);
		repeat (2) send_random(OP_NEXT);
		settle();
		write_count(4'd15);
		repeat (2) send_random(OP_NEXT);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			idle_pct = phase_idle[ph];
			stall_pct = phase_stall[ph];
			write_count(CNT_W'(phase_count[ph]));
			perms = 1;
			for (int k = 2; k <= phase_count[ph]; k++) begin
				perms = perms * k;
			end
			if (perms > 30) begin
				perms = 30;
			end
			sent = 0;
			if (ph == 0) begin
				hold_req = 1'b1;
				repeat (6) send_random(OP_NEXT);
				sent = 6;
			end
			while (sent < PHASE_LEN) begin
				if ($urandom_range(99) < 70) begin
					repeat ($urandom_range(0, 2)) begin
						send_random(OP_LOAD);
						sent++;
					end
					run_len = $urandom_range(1, perms + 2);
					repeat (run_len) send_random(OP_NEXT);
					sent += run_len;
				end else begin
					case ($urandom_range(2))
						0: begin
							send_random(OP_LOAD);
							sent++;
						end
						1: begin
							send_random(OP_RESTART);
							sent++;
						end
						default: begin
							send_random(OP_UNUSED);
						end
					endcase
				end
			end
		end

		settle();
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
sv/spg_pkg.sv
sv/spg_sequencer.sv
sv/spg_datapath.sv
sv/swap_permutation_generator_core.sv
sim/swap_permutation_generator_checker.sv
sim/swap_permutation_generator_core_test.sv
